/* src/cit_pkg.sv */
// cit_pkg: shared types and constants for the cue index track range block
// used by cit_track_state and cue_index_track_range

package cit_pkg;

    // frame position width kept in state, 20 to 32
    localparam int FRAME_BITS = 24;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 24;
    localparam int LEN_W    = 28;
    localparam int ORD_W    = 16;
    localparam int GAP_W    = 2;

    // output word: start, end, length, ordinal, padded to whole bytes
    localparam int OUT_FIELDS_W = 2 * POS_W + LEN_W + ORD_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    // length arithmetic: len = 13*d + d/3, d/3 by reciprocal multiply
    localparam int          RECIP_W     = 32;
    localparam logic [31:0] RECIP3      = 32'hAAAA_AAAB;
    localparam int          RECIP_SHIFT = 33;
    localparam int          LEN_CALC_W  = (FRAME_BITS + 5 > LEN_W + 1) ?
                                          FRAME_BITS + 5 : LEN_W + 1;

    localparam logic [ORD_W-1:0] ORD_MAX = {ORD_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_FILE   = 3'd0,
        OP_TRACK  = 3'd1,
        OP_INDEX0 = 3'd2,
        OP_INDEX  = 3'd3,
        OP_END    = 3'd4
    } op_t;

    typedef enum logic [GAP_W-1:0] {
        GAP_PREV       = 2'd0,
        GAP_KEEP_FIRST = 2'd1,
        GAP_CURRENT    = 2'd2,
        GAP_SKIP       = 2'd3
    } gap_mode_t;

    typedef struct packed {
        logic [POS_W-1:0]      start_pos;
        logic [POS_W-1:0]      end_pos;
        logic                  open_end;
        logic                  invalid;
        logic [FRAME_BITS-1:0] diff;
        logic [ORD_W-1:0]      ordinal;
    } range_t;

endpackage

/* src/cit_track_state.sv */
// cit_track_state: cue event state (carried start, pending range, flags,
// range counter) and the range emitted by each event; uses cit_pkg

module cit_track_state (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  logic [cit_pkg::OPCODE_W-1:0]   opcode,
    input  logic [cit_pkg::POS_W-1:0]      frame_position,
    input  cit_pkg::gap_mode_t             gap_mode,
    output logic                           emit,
    output cit_pkg::range_t                rng
);

    localparam int FB = cit_pkg::FRAME_BITS;

    logic [FB-1:0]              carried_start_reg, carried_start_next;
    logic                       carried_valid_reg, carried_valid_next;
    logic [FB-1:0]              pending_start_reg, pending_start_next;
    logic                       pending_start_valid_reg, pending_start_valid_next;
    logic [FB-1:0]              pending_end_reg, pending_end_next;
    logic                       pending_end_valid_reg, pending_end_valid_next;
    logic                       awaiting_reg, awaiting_next;
    logic                       emitted_reg, emitted_next;
    logic                       file_open_reg, file_open_next;
    logic [cit_pkg::ORD_W-1:0]  counter_reg, counter_next;

    logic [FB-1:0] v;
    logic [FB-1:0] em_start;
    logic [FB-1:0] em_end;
    logic          em_start_ok;
    logic          em_open;
    logic          bad;

    assign v = FB'(frame_position);

    always_comb begin
        carried_start_next       = carried_start_reg;
        carried_valid_next       = carried_valid_reg;
        pending_start_next       = pending_start_reg;
        pending_start_valid_next = pending_start_valid_reg;
        pending_end_next         = pending_end_reg;
        pending_end_valid_next   = pending_end_valid_reg;
        awaiting_next            = awaiting_reg;
        emitted_next             = emitted_reg;
        file_open_next           = file_open_reg;
        emit        = 1'b0;
        em_start    = carried_start_reg;
        em_start_ok = carried_valid_reg;
        em_end      = '0;
        em_open     = 1'b1;

        unique case (cit_pkg::op_t'(opcode))
            cit_pkg::OP_FILE: begin
                // an open file closes with an open-ended final range
                emit                     = file_open_reg;
                pending_start_next       = '0;
                pending_start_valid_next = 1'b0;
                pending_end_next         = '0;
                pending_end_valid_next   = 1'b0;
                emitted_next             = 1'b0;
                carried_start_next       = '0;
                carried_valid_next       = 1'b0;
                awaiting_next            = 1'b1;
                file_open_next           = 1'b1;
            end
            cit_pkg::OP_TRACK: begin
                pending_start_valid_next = 1'b0;
                pending_end_valid_next   = 1'b0;
                emitted_next             = 1'b0;
            end
            cit_pkg::OP_INDEX0: begin
                if (awaiting_reg) begin
                    if (gap_mode == cit_pkg::GAP_KEEP_FIRST ||
                        gap_mode == cit_pkg::GAP_CURRENT) begin
                        carried_start_next = v;
                        carried_valid_next = 1'b1;
                    end
                end else if (gap_mode == cit_pkg::GAP_SKIP) begin
                    pending_end_next       = v;
                    pending_end_valid_next = 1'b1;
                end else if (gap_mode == cit_pkg::GAP_CURRENT) begin
                    pending_end_next         = v;
                    pending_end_valid_next   = 1'b1;
                    pending_start_next       = carried_start_reg;
                    pending_start_valid_next = carried_valid_reg;
                    carried_start_next       = v;
                    carried_valid_next       = 1'b1;
                end
            end
            cit_pkg::OP_INDEX: begin
                if (awaiting_reg) begin
                    awaiting_next = 1'b0;
                    if (!carried_valid_reg) begin
                        carried_start_next = v;
                        carried_valid_next = 1'b1;
                    end
                end else if (!emitted_reg) begin
                    if (!pending_start_valid_reg) begin
                        pending_start_next       = carried_start_reg;
                        pending_start_valid_next = carried_valid_reg;
                        carried_start_next       = v;
                        carried_valid_next       = 1'b1;
                    end
                    if (!pending_end_valid_reg) begin
                        pending_end_next       = v;
                        pending_end_valid_next = 1'b1;
                    end
                    emitted_next = 1'b1;
                    emit         = 1'b1;
                    em_start     = pending_start_next;
                    em_start_ok  = pending_start_valid_next;
                    em_end       = pending_end_next;
                    em_open      = 1'b0;
                end
            end
            cit_pkg::OP_END: begin
                if (file_open_reg) begin
                    emit                     = 1'b1;
                    pending_start_next       = carried_start_reg;
                    pending_start_valid_next = carried_valid_reg;
                    pending_end_next         = '0;
                    pending_end_valid_next   = 1'b0;
                end
                file_open_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        counter_next = counter_reg;
        if (emit && counter_reg != cit_pkg::ORD_MAX) begin
            counter_next = counter_reg + 1'b1;
        end
    end

    assign bad = !em_start_ok || (!em_open && em_start >= em_end);

    always_comb begin
        rng.start_pos = em_start_ok ? cit_pkg::POS_W'(em_start) : '0;
        rng.end_pos   = em_open ? '0 : cit_pkg::POS_W'(em_end);
        rng.open_end  = em_open;
        rng.invalid   = bad;
        rng.diff      = (em_open || bad) ? '0 : em_end - em_start;
        rng.ordinal   = counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carried_start_reg       <= '0;
            carried_valid_reg       <= 1'b0;
            pending_start_reg       <= '0;
            pending_start_valid_reg <= 1'b0;
            pending_end_reg         <= '0;
            pending_end_valid_reg   <= 1'b0;
            awaiting_reg            <= 1'b0;
            emitted_reg             <= 1'b0;
            file_open_reg           <= 1'b0;
            counter_reg             <= '0;
        end else if (step_en) begin
            carried_start_reg       <= carried_start_next;
            carried_valid_reg       <= carried_valid_next;
            pending_start_reg       <= pending_start_next;
            pending_start_valid_reg <= pending_start_valid_next;
            pending_end_reg         <= pending_end_next;
            pending_end_valid_reg   <= pending_end_valid_next;
            awaiting_reg            <= awaiting_next;
            emitted_reg             <= emitted_next;
            file_open_reg           <= file_open_next;
            counter_reg             <= counter_next;
        end
    end

endmodule

/* src/cue_index_track_range.sv */
// cue_index_track_range: turns cue-sheet index events into track ranges
// depends on cit_pkg and cit_track_state
//
// usage:
//   s_ channel carries one event word per handshake: tuser is the opcode
//   (file start, track, index 00, other index, end of sheet), tdata the
//   index position in cd frames. events that close a track give one range
//   word on the m_ channel; other events give none.
//   gap_mode is written through cfg_we/cfg_wdata while the block is idle.
// pipeline and throughput:
//   one event per cycle while s_tready is high. a range word passes two registers:
//   the first holds the emitted range, the second the output word with the length in
//   milliseconds, formed by one 32x32 reciprocal multiply for the /3.
// reset and stalls:
//   aresetn (sync, active low) clears the event state, the range counter,
//   gap_mode and both result stages. while m_tready is low, the two stages
//   fill and s_tready drops only once both hold a word.

module cue_index_track_range (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cit_pkg::GAP_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [23:0] frame_position
    input  logic [cit_pkg::POS_W-1:0]         s_tdata,
    // [2:0] opcode
    input  logic [cit_pkg::OPCODE_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] range_start, [47:24] range_end, [75:48] length_ms,
    // [91:76] track_ordinal, [95:92] zero
    output logic [cit_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [0] open_ended, [1] range_invalid
    output logic [cit_pkg::OUT_USER_W-1:0]    m_tuser
);

    localparam int LW = cit_pkg::LEN_CALC_W;

    cit_pkg::gap_mode_t gap_mode_reg;
    logic               a_valid_reg;
    cit_pkg::range_t    a_range_reg;
    logic               m_valid_reg;
    logic [cit_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [cit_pkg::OUT_USER_W-1:0] m_user_reg;

    logic            out_adv;
    logic            a_adv;
    logic            s_accept;
    logic            emit;
    cit_pkg::range_t step_range;

    logic [cit_pkg::RECIP_W-1:0]     diff_ext;
    logic [2*cit_pkg::RECIP_W-1:0]   recip_prod;
    logic [LW-1:0]                   third;
    logic [LW-1:0]                   diff_lw;
    logic [LW-1:0]                   len_sum;
    logic [cit_pkg::LEN_W-1:0]       len_ms;

    assign out_adv  = !m_valid_reg || m_tready;
    assign a_adv    = !a_valid_reg || out_adv;
    assign s_tready = a_adv;
    assign s_accept = s_tvalid && a_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_mode_reg <= cit_pkg::GAP_PREV;
        end else if (cfg_we) begin
            gap_mode_reg <= cit_pkg::gap_mode_t'(cfg_wdata);
        end
    end

    cit_track_state u_state (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (s_accept),
        .opcode         (s_tuser),
        .frame_position (s_tdata),
        .gap_mode       (gap_mode_reg),
        .emit           (emit),
        .rng            (step_range)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_adv) begin
            a_valid_reg <= s_accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && s_accept && emit) begin
            a_range_reg <= step_range;
        end
    end

    // (end - start) * 1000 / 75 = 13*d + floor(d/3)
    assign diff_ext   = cit_pkg::RECIP_W'(a_range_reg.diff);
    assign recip_prod = {{cit_pkg::RECIP_W{1'b0}}, diff_ext} *
                        {{cit_pkg::RECIP_W{1'b0}}, cit_pkg::RECIP3};
    assign third      = LW'(recip_prod >> cit_pkg::RECIP_SHIFT);
    assign diff_lw    = LW'(a_range_reg.diff);
    assign len_sum    = (diff_lw << 3) + (diff_lw << 2) + diff_lw + third;
    assign len_ms     = (len_sum > LW'(cit_pkg::LEN_MAX)) ? cit_pkg::LEN_MAX :
                        cit_pkg::LEN_W'(len_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && a_valid_reg) begin
            m_data_reg <= cit_pkg::OUT_DATA_W'({a_range_reg.ordinal, len_ms,
                                                a_range_reg.end_pos,
                                                a_range_reg.start_pos});
            m_user_reg <= {a_range_reg.invalid, a_range_reg.open_end};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // every emitted range has a nonzero ordinal
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[91:76] != '0)
        else $error("range word with zero ordinal");

    // open-ended ranges carry no end and no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[47:24] == '0 && m_tdata[75:48] == '0)
        else $error("open-ended range with end or length");

    // invalid ranges carry no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[75:48] == '0)
        else $error("invalid range with nonzero length");

    // a held middle-stage word is not overwritten while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !out_adv |=> a_valid_reg && $stable(a_range_reg))
        else $error("middle stage lost a word under stall");

    // no new event is taken while both stages are full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted with both stages full");

endmodule

/* sim/cue_index_track_range_test.sv */
// cue_index_track_range_test: self-checking bench for the cue index track range block
// streams cue-sheet events, predicts every range word locally and checks the m_ channel
// depends on cit_pkg and cue_index_track_range

`timescale 1ns / 100ps

module cue_index_track_range_test;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_EVENTS = 85;
    localparam logic [cit_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [cit_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [cit_pkg::OPCODE_W-1:0] op;
        logic [cit_pkg::POS_W-1:0]    pos;
    } cue_event_t;

    typedef struct {
        logic [cit_pkg::POS_W-1:0] rng_start;
        logic [cit_pkg::POS_W-1:0] rng_end;
        logic                      rng_open;
        logic [cit_pkg::LEN_W-1:0] rng_len;
        logic                      rng_bad;
        logic [cit_pkg::ORD_W-1:0] rng_ord;
    } range_word_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [cit_pkg::GAP_W-1:0]      cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cit_pkg::POS_W-1:0]      s_tdata = '0;
    logic [cit_pkg::OPCODE_W-1:0]   s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cit_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [cit_pkg::OUT_USER_W-1:0] m_tuser;

    cue_event_t  pending_events[$];
    range_word_t ranges_due[$];
    cue_event_t  next_ev;
    range_word_t got, want;

    int  err_count = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    int  stall_cycles = 0;
    int  events_queued = 0;
    bit  no_idle = 1'b0;

    // local copy of the block state
    cit_pkg::gap_mode_t             gap_sel = cit_pkg::GAP_PREV;
    logic [cit_pkg::FRAME_BITS-1:0] cue_carry_start = '0;
    logic                           cue_carry_ok = 1'b0;
    logic [cit_pkg::FRAME_BITS-1:0] trk_start = '0;
    logic                           trk_start_ok = 1'b0;
    logic [cit_pkg::FRAME_BITS-1:0] trk_end = '0;
    logic                           trk_end_ok = 1'b0;
    logic                           wait_first_idx = 1'b0;
    logic                           trk_emitted = 1'b0;
    logic                           file_active = 1'b0;
    logic [cit_pkg::ORD_W-1:0]      ranges_made = '0;

    cue_index_track_range DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic push_range(input logic [cit_pkg::FRAME_BITS-1:0] st, input logic st_ok,
                              input logic [cit_pkg::FRAME_BITS-1:0] en, input logic open);
        range_word_t r;
        logic bad;
        longint unsigned span, len;
        bad = !st_ok || (!open && st >= en);
        len = 0;
        if (!open && !bad) begin
            span = en - st;
            len = span * 1000 / 75;
            if (len > cit_pkg::LEN_MAX) len = cit_pkg::LEN_MAX;
        end
        if (ranges_made < cit_pkg::ORD_MAX) ranges_made++;
        r.rng_start = st_ok ? cit_pkg::POS_W'(st) : '0;
        r.rng_end   = open ? '0 : cit_pkg::POS_W'(en);
        r.rng_open  = open;
        r.rng_len   = cit_pkg::LEN_W'(len);
        r.rng_bad   = bad;
        r.rng_ord   = ranges_made;
        ranges_due.push_back(r);
    endtask

    // open file closes with an open-ended range from the carried start
    task automatic close_file();
        trk_start    = cue_carry_start;
        trk_start_ok = cue_carry_ok;
        trk_end      = '0;
        trk_end_ok   = 1'b0;
        push_range(cue_carry_start, cue_carry_ok, '0, 1'b1);
    endtask

    task automatic track_range_model(input logic [cit_pkg::OPCODE_W-1:0] op,
                                     input logic [cit_pkg::POS_W-1:0] pos);
        logic [cit_pkg::FRAME_BITS-1:0] v;
        v = cit_pkg::FRAME_BITS'(pos);
        case (op)
            cit_pkg::OP_FILE: begin
                if (file_active) close_file();
                trk_start       = '0;
                trk_start_ok    = 1'b0;
                trk_end         = '0;
                trk_end_ok      = 1'b0;
                trk_emitted     = 1'b0;
                cue_carry_start = '0;
                cue_carry_ok    = 1'b0;
                wait_first_idx  = 1'b1;
                file_active     = 1'b1;
            end
            cit_pkg::OP_TRACK: begin
                trk_start_ok = 1'b0;
                trk_end_ok   = 1'b0;
                trk_emitted  = 1'b0;
            end
            cit_pkg::OP_INDEX0: begin
                if (wait_first_idx) begin
                    if (gap_sel == cit_pkg::GAP_KEEP_FIRST ||
                        gap_sel == cit_pkg::GAP_CURRENT) begin
                        cue_carry_start = v;
                        cue_carry_ok    = 1'b1;
                    end
                end else if (gap_sel == cit_pkg::GAP_SKIP) begin
                    trk_end    = v;
                    trk_end_ok = 1'b1;
                end else if (gap_sel == cit_pkg::GAP_CURRENT) begin
                    trk_end         = v;
                    trk_end_ok      = 1'b1;
                    trk_start       = cue_carry_start;
                    trk_start_ok    = cue_carry_ok;
                    cue_carry_start = v;
                    cue_carry_ok    = 1'b1;
                end
            end
            cit_pkg::OP_INDEX: begin
                if (wait_first_idx) begin
                    wait_first_idx = 1'b0;
                    if (!cue_carry_ok) begin
                        cue_carry_start = v;
                        cue_carry_ok    = 1'b1;
                    end
                end else if (!trk_emitted) begin
                    if (!trk_start_ok) begin
                        trk_start       = cue_carry_start;
                        trk_start_ok    = cue_carry_ok;
                        cue_carry_start = v;
                        cue_carry_ok    = 1'b1;
                    end
                    if (!trk_end_ok) begin
                        trk_end    = v;
                        trk_end_ok = 1'b1;
                    end
                    trk_emitted = 1'b1;
                    push_range(trk_start, trk_start_ok, trk_end, 1'b0);
                end
            end
            cit_pkg::OP_END: begin
                if (file_active) close_file();
                file_active = 1'b0;
            end
            default: ;
        endcase
    endtask

    // driver: one word on the bus at a time, random idle bursts between words unless no_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) track_range_model(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        src_gap = $urandom_range(0, 15);
                        s_tvalid <= 1'b0;
                    end else begin
                        next_ev = pending_events.pop_front();
                        s_tvalid <= 1'b1;
                        s_tdata  <= next_ev.pos;
                        s_tuser  <= next_ev.op;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each range word against the oldest prediction and drive m_tready with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.rng_start = m_tdata[23:0];
                got.rng_end   = m_tdata[47:24];
                got.rng_len   = m_tdata[75:48];
                got.rng_ord   = m_tdata[91:76];
                got.rng_open  = m_tuser[0];
                got.rng_bad   = m_tuser[1];
                if (ranges_due.size() == 0) begin
                    $error("range word with none expected: start %0d end %0d",
                           got.rng_start, got.rng_end);
                    err_count++;
                end else begin
                    want = ranges_due.pop_front();
                    if (got.rng_start !== want.rng_start) begin
                        $error("range_start: expected %0d, got %0d",
                               want.rng_start, got.rng_start);
                        err_count++;
                    end
                    if (got.rng_end !== want.rng_end) begin
                        $error("range_end: expected %0d, got %0d",
                               want.rng_end, got.rng_end);
                        err_count++;
                    end
                    if (got.rng_open !== want.rng_open) begin
                        $error("open_ended: expected %0d, got %0d",
                               want.rng_open, got.rng_open);
                        err_count++;
                    end
                    if (got.rng_len !== want.rng_len) begin
                        $error("length_ms: expected %0d, got %0d",
                               want.rng_len, got.rng_len);
                        err_count++;
                    end
                    if (got.rng_bad !== want.rng_bad) begin
                        $error("range_invalid: expected %0d, got %0d",
                               want.rng_bad, got.rng_bad);
                        err_count++;
                    end
                    if (got.rng_ord !== want.rng_ord) begin
                        $error("track_ordinal: expected %0d, got %0d",
                               want.rng_ord, got.rng_ord);
                        err_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("cue_index_track_range_test: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_event(input logic [cit_pkg::OPCODE_W-1:0] op,
                             input logic [cit_pkg::POS_W-1:0] pos);
        cue_event_t ev;
        ev.op  = op;
        ev.pos = pos;
        pending_events.push_back(ev);
        if (op <= cit_pkg::OP_END) events_queued++;
    endtask

    // one sheet: file, tracks with optional pregap, then zero, one or two closes
    task automatic gen_cue_sheet();
        logic [cit_pkg::POS_W-1:0] p;
        int ntr;
        p = ($urandom_range(0, 3) == 0) ? cit_pkg::POS_W'($urandom) :
                                          cit_pkg::POS_W'($urandom_range(0, 2000));
        add_event(cit_pkg::OP_FILE, cit_pkg::POS_W'($urandom));
        ntr = $urandom_range(1, 6);
        for (int i = 0; i < ntr; i++) begin
            add_event(cit_pkg::OP_TRACK, cit_pkg::POS_W'($urandom));
            if ($urandom_range(0, 1) == 1) begin
                add_event(cit_pkg::OP_INDEX0, p);
                p = p + cit_pkg::POS_W'($urandom_range(0, 300));
            end
            add_event(cit_pkg::OP_INDEX, p);
            if ($urandom_range(0, 7) == 0)
                add_event(cit_pkg::OP_INDEX, p + cit_pkg::POS_W'($urandom_range(1, 100)));
            case ($urandom_range(0, 9))
                0: p = cit_pkg::POS_W'($urandom);
                1: p = p - cit_pkg::POS_W'($urandom_range(0, 500));
                2: p = {cit_pkg::POS_W{1'b1}} - cit_pkg::POS_W'($urandom_range(0, 3));
                default: p = p + cit_pkg::POS_W'($urandom_range(1, 20000));
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                add_event(cit_pkg::OP_END, cit_pkg::POS_W'($urandom));
                add_event(cit_pkg::OP_END, cit_pkg::POS_W'($urandom));
            end
            1: ;
            default: add_event(cit_pkg::OP_END, cit_pkg::POS_W'($urandom));
        endcase
    endtask

    task automatic fill_phase(input int n);
        int target;
        target = events_queued + n;
        while (events_queued < target) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_event(cit_pkg::OPCODE_W'($urandom_range(0, 7)),
                              cit_pkg::POS_W'($urandom));
            end else begin
                gen_cue_sheet();
            end
        end
    endtask

    // results trail their event through the middle and output registers; words with no result need settling too
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_events.size() > 0 || s_tvalid || ranges_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_gap_mode(input cit_pkg::gap_mode_t mode);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        gap_sel = mode;
    endtask

    cit_pkg::gap_mode_t mode_plan[7] = '{cit_pkg::GAP_KEEP_FIRST, cit_pkg::GAP_CURRENT,
                                         cit_pkg::GAP_SKIP, cit_pkg::GAP_PREV,
                                         cit_pkg::GAP_SKIP, cit_pkg::GAP_CURRENT,
                                         cit_pkg::GAP_KEEP_FIRST};

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, gap mode at its reset value
        add_event(cit_pkg::OP_INDEX, 24'd100);
        add_event(cit_pkg::OP_END, 24'd0);
        add_event(OP_UNUSED_LO, {cit_pkg::POS_W{1'b1}});
        add_event(OP_UNUSED_LO + 3'd1, 24'd0);
        add_event(OP_UNUSED_HI, {cit_pkg::POS_W{1'b1}});
        add_event(cit_pkg::OP_FILE, 24'd0);
        add_event(cit_pkg::OP_TRACK, {cit_pkg::POS_W{1'b1}});
        add_event(cit_pkg::OP_INDEX0, 24'd10);
        add_event(cit_pkg::OP_INDEX, 24'd0);
        add_event(cit_pkg::OP_TRACK, 24'd0);
        add_event(cit_pkg::OP_INDEX0, 24'd500);
        add_event(cit_pkg::OP_INDEX, {cit_pkg::POS_W{1'b1}});
        add_event(cit_pkg::OP_INDEX, 24'd7);
        add_event(cit_pkg::OP_TRACK, 24'd0);
        add_event(cit_pkg::OP_INDEX, 24'd0);
        add_event(cit_pkg::OP_END, 24'd0);
        add_event(cit_pkg::OP_END, 24'd0);
        add_event(cit_pkg::OP_FILE, 24'd0);
        add_event(cit_pkg::OP_FILE, 24'd0);
        add_event(cit_pkg::OP_TRACK, 24'd0);
        add_event(cit_pkg::OP_INDEX, 24'h555555);
        add_event(cit_pkg::OP_TRACK, 24'd0);
        add_event(cit_pkg::OP_INDEX, 24'hAAAAAA);
        add_event(cit_pkg::OP_END, 24'd0);
        wait_idle();

        foreach (mode_plan[i]) begin
            write_gap_mode(mode_plan[i]);
            fill_phase(PHASE_EVENTS);
            wait_idle();
        end

        // closing stretch at full rate on both sides
        no_idle = 1'b1;
        write_gap_mode(cit_pkg::gap_mode_t'($urandom_range(0, 3)));
        fill_phase(PHASE_EVENTS);
        wait_idle();

        if (err_count == 0) begin
            $display("cue_index_track_range_test: done, clean");
        end else begin
            $display("cue_index_track_range_test: done, errors");
        end
        $finish;
    end

endmodule
